>>> src/shbd_pkg.sv
package shbd_pkg;

    localparam int MAX_BOARDS       = 32;
    localparam int STRIPS_PER_BOARD = 128;

    localparam int BOARD_W   = 5;
    localparam int WORD_W    = 32;
    localparam int STRIP_W   = 12;
    localparam int CLOCK_W   = 11;
    localparam int POS_W     = 3;
    localparam int WIDX_W    = 2;
    localparam int BIT_IDX_W = $clog2(WORD_W);

    localparam logic [POS_W-1:0] POS_STAMP = 3'd0;
    localparam logic [POS_W-1:0] POS_LAST  = 3'd4;

    typedef struct packed {
        logic [BOARD_W-1:0] board_index;
        logic [WORD_W-1:0]  data_word;
        logic               event_start;
        logic               board_start;
    } in_item_t;

    typedef struct packed {
        logic [STRIP_W-1:0] strip_number;
        logic [CLOCK_W-1:0] hit_clock;
        logic [STRIP_W-1:0] min_strip;
        logic [STRIP_W-1:0] max_strip;
        logic [CLOCK_W-1:0] min_clock;
        logic [CLOCK_W-1:0] max_clock;
        logic               last_of_word;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mask_any;
        logic mask_last;
        logic out_free;
    } ctrl_status_t;

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] result;
        for (int i = 0; i < WORD_W; i++)
        begin
            result[i] = value[WORD_W-1-i];
        end
        return result;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] value);
        logic [BIT_IDX_W-1:0] result;
        result = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (value[i])
            begin
                result = BIT_IDX_W'(i);
            end
        end
        return result;
    endfunction

endpackage

>>> src/shbd_in_if.sv
interface shbd_in_if;
    logic               valid;
    logic               ready;
    shbd_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/shbd_out_if.sv
interface shbd_out_if;
    logic                valid;
    logic                ready;
    shbd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/strip_hit_bitmap_decoder_unit.sv
// Channel   Role    Handshake       Payload
// stream    sink    valid / ready   board_index, data_word, event_start, board_start
// hits      source  valid / ready   strip_number, hit_clock, box bounds, last_of_word
// cfg       write   cfg_wr_en       cfg_wr_data (reverse_bit_order)
//
// One item is taken per pass; a bitmap word then gives one hit per
// set bit, found lowest first by a priority encoder.
// A time-stamp or empty word loads an empty bitmap and gives no hit.
// Reset is asynchronous and needs no clearing pass.
// A stalled hits channel holds the scan; the next item is taken while the last hit waits.
module strip_hit_bitmap_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    shbd_in_if.sink    stream,
    shbd_out_if.source hits
);

    shbd_pkg::ctrl_cmd_t    cmd;
    shbd_pkg::ctrl_status_t status;

    shbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    shbd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (stream.data),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (hits.ready),
        .out_valid   (hits.valid),
        .out_item    (hits.data)
    );

endmodule

>>> src/shbd_ctrl.sv
module shbd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  shbd_pkg::ctrl_status_t status,
    output shbd_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (!status.mask_any)
                begin
                    state_next = IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.mask_last)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/shbd_datapath.sv
module shbd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    input  shbd_pkg::in_item_t     in_item,
    input  shbd_pkg::ctrl_cmd_t    cmd,
    output shbd_pkg::ctrl_status_t status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output shbd_pkg::out_item_t    out_item
);

    logic                             reverse_reg;
    logic [shbd_pkg::POS_W-1:0]       record_position_reg;
    logic [shbd_pkg::POS_W-1:0]       record_position_next;
    logic [shbd_pkg::CLOCK_W-1:0]     record_clock_reg;
    logic [shbd_pkg::STRIP_W-1:0]     box_min_strip_reg;
    logic [shbd_pkg::STRIP_W-1:0]     box_max_strip_reg;
    logic [shbd_pkg::CLOCK_W-1:0]     box_min_clock_reg;
    logic [shbd_pkg::CLOCK_W-1:0]     box_max_clock_reg;
    logic                             box_valid_reg;
    logic [shbd_pkg::WORD_W-1:0]      mask_reg;
    logic [shbd_pkg::WORD_W-1:0]      mask_next;
    logic [shbd_pkg::STRIP_W-1:0]     base_reg;
    logic [shbd_pkg::STRIP_W-1:0]     base_next;
    logic                             out_valid_reg;
    shbd_pkg::out_item_t              out_item_reg;

    logic [shbd_pkg::POS_W-1:0]       pos_raw;
    logic [shbd_pkg::POS_W-1:0]       pos;
    logic [shbd_pkg::WIDX_W-1:0]      widx;
    logic [shbd_pkg::STRIP_W-1:0]     word_offset;
    logic                             board_ok;
    logic                             word_ok;
    logic                             hits_ok;
    logic [shbd_pkg::WORD_W-1:0]      oriented_word;

    logic [shbd_pkg::BIT_IDX_W-1:0]   hit_bit;
    logic [shbd_pkg::WORD_W-1:0]      mask_rest;
    logic [shbd_pkg::STRIP_W-1:0]     hit_strip;
    logic [shbd_pkg::STRIP_W-1:0]     new_min_strip;
    logic [shbd_pkg::STRIP_W-1:0]     new_max_strip;
    logic [shbd_pkg::CLOCK_W-1:0]     new_min_clock;
    logic [shbd_pkg::CLOCK_W-1:0]     new_max_clock;

    always_comb
    begin
        pos_raw = in_item.board_start ? shbd_pkg::POS_STAMP : record_position_reg;
        pos     = (pos_raw > shbd_pkg::POS_LAST) ? shbd_pkg::POS_STAMP : pos_raw;
        record_position_next = (pos == shbd_pkg::POS_LAST)
            ? shbd_pkg::POS_STAMP : shbd_pkg::POS_W'(pos + 1'b1);
        widx        = shbd_pkg::WIDX_W'(pos - 1'b1);
        word_offset = shbd_pkg::STRIP_W'(widx) << shbd_pkg::BIT_IDX_W;
        board_ok    = ({1'b0, in_item.board_index} < (shbd_pkg::BOARD_W + 1)'(shbd_pkg::MAX_BOARDS));
        word_ok     = (word_offset < shbd_pkg::STRIP_W'(shbd_pkg::STRIPS_PER_BOARD));
        hits_ok     = (pos != shbd_pkg::POS_STAMP) && board_ok && word_ok;
        oriented_word = reverse_reg ? shbd_pkg::bit_reverse(in_item.data_word)
                                    : in_item.data_word;
        base_next = shbd_pkg::STRIP_W'(shbd_pkg::STRIP_W'(in_item.board_index)
                    * shbd_pkg::STRIP_W'(shbd_pkg::STRIPS_PER_BOARD)) + word_offset;
    end

    always_comb
    begin
        hit_bit   = shbd_pkg::lowest_set(mask_reg);
        mask_rest = mask_reg & (mask_reg - 1'b1);
        hit_strip = base_reg + shbd_pkg::STRIP_W'(hit_bit);
        if (!box_valid_reg)
        begin
            new_min_strip = hit_strip;
            new_max_strip = hit_strip;
            new_min_clock = record_clock_reg;
            new_max_clock = record_clock_reg;
        end
        else
        begin
            new_min_strip = (hit_strip < box_min_strip_reg) ? hit_strip : box_min_strip_reg;
            new_max_strip = (hit_strip > box_max_strip_reg) ? hit_strip : box_max_strip_reg;
            new_min_clock = (record_clock_reg < box_min_clock_reg)
                ? record_clock_reg : box_min_clock_reg;
            new_max_clock = (record_clock_reg > box_max_clock_reg)
                ? record_clock_reg : box_max_clock_reg;
        end
        if (cmd.load)
        begin
            mask_next = hits_ok ? oriented_word : '0;
        end
        else if (cmd.step)
        begin
            mask_next = mask_rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg         <= 1'b0;
            record_position_reg <= shbd_pkg::POS_STAMP;
            record_clock_reg    <= '0;
            box_min_strip_reg   <= '0;
            box_max_strip_reg   <= '0;
            box_min_clock_reg   <= '0;
            box_max_clock_reg   <= '0;
            box_valid_reg       <= 1'b0;
            mask_reg            <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                reverse_reg <= cfg_wr_data;
            end
            mask_reg <= mask_next;
            if (cmd.load)
            begin
                record_position_reg <= record_position_next;
                if (pos == shbd_pkg::POS_STAMP)
                begin
                    record_clock_reg <= in_item.data_word[shbd_pkg::CLOCK_W-1:0];
                end
                if (in_item.event_start)
                begin
                    box_valid_reg <= 1'b0;
                end
            end
            if (cmd.step)
            begin
                box_min_strip_reg <= new_min_strip;
                box_max_strip_reg <= new_max_strip;
                box_min_clock_reg <= new_min_clock;
                box_max_clock_reg <= new_max_clock;
                box_valid_reg     <= 1'b1;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_next;
        end
        if (cmd.step)
        begin
            out_item_reg.strip_number <= hit_strip;
            out_item_reg.hit_clock    <= record_clock_reg;
            out_item_reg.min_strip    <= new_min_strip;
            out_item_reg.max_strip    <= new_max_strip;
            out_item_reg.min_clock    <= new_min_clock;
            out_item_reg.max_clock    <= new_max_clock;
            out_item_reg.last_of_word <= (mask_rest == '0);
        end
    end

    assign status.mask_any  = (mask_reg != '0);
    assign status.mask_last = (mask_rest == '0);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_item         = out_item_reg;

    a_step_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> mask_reg != '0)
        else $error("Hit emitted from an empty bitmap.");

    a_last_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.mask_last && !cmd.load |=> mask_reg == '0)
        else $error("Bitmap not empty after the last hit of a word.");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.min_strip <= out_item_reg.max_strip
            && out_item_reg.min_clock <= out_item_reg.max_clock)
        else $error("Bounding box out of order.");

    a_hit_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.strip_number >= out_item_reg.min_strip
            && out_item_reg.strip_number <= out_item_reg.max_strip
            && out_item_reg.hit_clock >= out_item_reg.min_clock
            && out_item_reg.hit_clock <= out_item_reg.max_clock)
        else $error("Hit lies outside the bounding box.");

endmodule
